@@ design/sdwt_pkg.sv @@
package sdwt_pkg;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_TEST  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        V_NEWEST = 2'd0,
        V_NEW    = 2'd1,
        V_DUP    = 2'd2,
        V_OLD    = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_TICK,
        ST_DONE
    } state_t;

    localparam int unsigned SEQ_W  = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned KEY_W  = 8 + 64 + 64 + 16;

endpackage

@@ design/seqno_duplicate_window_table.sv @@
// Duplicate-detection table with a per-originator sliding anti-replay window.
// Input channel: in_valid/in_ready carry one request (cmd, key fields, seqno,
// valid_ticks). Output channel: out_valid/out_ready carry one result (verdict,
// table_full) for every request, in order.
// Entries live in a synchronous memory with a registered read port; the
// valid bits and the clock counter are flip-flops.
// Add and test walk the table one entry per cycle for a key match and the
// lowest free entry, then classify and write back in the update state and
// load the result in the done state, where it moves to the output register
// once that register is free. A tick walks all entries once to expire those
// whose deadline has been reached; a clear goes straight to the done state.
// One request is in work at a time; the next is taken once the result sits
// in the output register, so a stalled receiver holds at most one result and
// blocks new requests only while that register is full and a new result is
// ready to go.
// Reset clears all valid bits and the clock counter; no clearing pass runs.
module seqno_duplicate_window_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int HISTORY_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  msg_kind,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    input  logic [7:0]  addr_family,
    input  logic [7:0]  prefix_len,
    input  logic [15:0] seqno,
    input  logic [23:0] valid_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  verdict,
    output logic        table_full
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ENT_W = sdwt_pkg::KEY_W + sdwt_pkg::SEQ_W + HISTORY_BITS
                           + sdwt_pkg::TIME_W;
    localparam int DL_LO = 0;
    localparam int HS_LO = sdwt_pkg::TIME_W;
    localparam int SQ_LO = HS_LO + HISTORY_BITS;
    localparam int KY_LO = SQ_LO + sdwt_pkg::SEQ_W;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(TABLE_ENTRIES);

    logic [ENT_W-1:0] mem [TABLE_ENTRIES];
    logic [ENT_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [31:0] time_reg;
    logic [31:0] time_next;

    sdwt_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] prev_reg;
    logic             prev_vld_reg;

    logic [1:0]              cmd_reg;
    logic [sdwt_pkg::KEY_W-1:0] key_reg;
    logic [15:0]             seq_reg;
    logic [23:0]             vt_reg;

    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [ENT_W-1:0] hit_ent_reg, hit_ent_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic       res_vld_reg;
    logic [1:0] verdict_reg;
    logic       full_reg;
    logic       res_load;
    logic [1:0] res_verdict;
    logic       res_full;

    // Classification values
    logic [15:0]             c_seq;
    logic [15:0]             seq_dist;
    logic [15:0]             back;
    logic                    ahead;
    logic [HISTORY_BITS-1:0] hist;
    logic [HISTORY_BITS-1:0] hist_shift;
    logic [HISTORY_BITS-1:0] bitmask;
    logic [31:0]             deadline_new;
    logic [31:0]             tick_diff;

    assign c_seq = hit_ent_reg[SQ_LO +: 16];
    assign hist  = hit_ent_reg[HS_LO +: HISTORY_BITS];
    assign seq_dist = seq_reg - c_seq;
    assign back  = 16'd0 - seq_dist;
    assign ahead = (seq_dist < 16'h8000) || (seq_dist == 16'h8000 && seq_reg > c_seq);
    assign hist_shift = (seq_dist > 16'(HISTORY_BITS - 1))
                        ? HISTORY_BITS'(1)
                        : ((hist << seq_dist[$clog2(HISTORY_BITS)-1:0])
                           | HISTORY_BITS'(1));
    assign bitmask = HISTORY_BITS'(1) << back[$clog2(HISTORY_BITS)-1:0];
    assign deadline_new = time_reg + {8'd0, vt_reg};
    assign tick_diff = time_reg - rd_data_reg[DL_LO +: 32];

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign mem_raddr = cnt_reg[IDX_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sdwt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (sdwt_pkg::cmd_t'(cmd))
                        sdwt_pkg::CMD_CLEAR: state_next = sdwt_pkg::ST_DONE;
                        sdwt_pkg::CMD_TICK:  state_next = sdwt_pkg::ST_TICK;
                        default:             state_next = sdwt_pkg::ST_SCAN;
                    endcase
                end
            end
            sdwt_pkg::ST_SCAN:
            begin
                if (cnt_reg == LAST)
                begin
                    state_next = sdwt_pkg::ST_UPDATE;
                end
            end
            sdwt_pkg::ST_TICK:
            begin
                if (cnt_reg == LAST)
                begin
                    state_next = sdwt_pkg::ST_DONE;
                end
            end
            sdwt_pkg::ST_UPDATE: state_next = sdwt_pkg::ST_DONE;
            sdwt_pkg::ST_DONE:
            begin
                if (!res_vld_reg || out_ready)
                begin
                    state_next = sdwt_pkg::ST_IDLE;
                end
            end
            default: state_next = sdwt_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        in_ready      = (state_reg == sdwt_pkg::ST_IDLE);
        cnt_next      = cnt_reg;
        valid_next    = valid_reg;
        time_next     = time_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_ent_next  = hit_ent_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        mem_we        = 1'b0;
        mem_waddr     = hit_idx_reg;
        mem_wdata     = hit_ent_reg;
        res_load      = 1'b0;
        res_verdict   = sdwt_pkg::V_NEWEST;
        res_full      = 1'b0;
        case (state_reg)
            sdwt_pkg::ST_IDLE:
            begin
                cnt_next  = '0;
                hit_next  = 1'b0;
                free_next = 1'b0;
                if (in_valid && sdwt_pkg::cmd_t'(cmd) == sdwt_pkg::CMD_TICK)
                begin
                    time_next = time_reg + 32'd1;
                end
                if (in_valid && sdwt_pkg::cmd_t'(cmd) == sdwt_pkg::CMD_CLEAR)
                begin
                    valid_next = '0;
                end
            end
            sdwt_pkg::ST_SCAN:
            begin
                if (cnt_reg != LAST)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                // Examine the entry read in the previous cycle
                if (prev_vld_reg)
                begin
                    if (valid_reg[prev_reg])
                    begin
                        if (!hit_reg && rd_data_reg[KY_LO +: sdwt_pkg::KEY_W] == key_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = prev_reg;
                            hit_ent_next = rd_data_reg;
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = prev_reg;
                    end
                end
            end
            sdwt_pkg::ST_TICK:
            begin
                if (cnt_reg != LAST)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (prev_vld_reg && valid_reg[prev_reg] && !tick_diff[31])
                begin
                    valid_next[prev_reg] = 1'b0;
                end
            end
            sdwt_pkg::ST_UPDATE:
            begin
                res_load = 1'b1;
                if (hit_reg)
                begin
                    mem_wdata[DL_LO +: 32] = deadline_new;
                    if (seq_dist == 16'd0)
                    begin
                        res_verdict = sdwt_pkg::V_DUP;
                    end
                    else if (ahead)
                    begin
                        res_verdict = sdwt_pkg::V_NEWEST;
                        mem_wdata[SQ_LO +: 16] = seq_reg;
                        mem_wdata[HS_LO +: HISTORY_BITS] = hist_shift;
                        mem_we = (sdwt_pkg::cmd_t'(cmd_reg) == sdwt_pkg::CMD_ADD);
                    end
                    else if (back > 16'(HISTORY_BITS - 1))
                    begin
                        res_verdict = sdwt_pkg::V_OLD;
                    end
                    else if ((hist & bitmask) != '0)
                    begin
                        res_verdict = sdwt_pkg::V_DUP;
                    end
                    else
                    begin
                        res_verdict = sdwt_pkg::V_NEW;
                        mem_wdata[HS_LO +: HISTORY_BITS] = hist | bitmask;
                        mem_we = (sdwt_pkg::cmd_t'(cmd_reg) == sdwt_pkg::CMD_ADD);
                    end
                end
                else if (sdwt_pkg::cmd_t'(cmd_reg) == sdwt_pkg::CMD_ADD)
                begin
                    if (!free_reg)
                    begin
                        res_verdict = sdwt_pkg::V_OLD;
                        res_full    = 1'b1;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = free_idx_reg;
                        mem_wdata = {key_reg, seq_reg, HISTORY_BITS'(1), deadline_new};
                        valid_next[free_idx_reg] = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sdwt_pkg::ST_IDLE;
            cnt_reg      <= '0;
            prev_vld_reg <= 1'b0;
            valid_reg    <= '0;
            time_reg     <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            prev_vld_reg <= (state_reg == sdwt_pkg::ST_SCAN || state_reg == sdwt_pkg::ST_TICK)
                            && cnt_reg != LAST;
            valid_reg    <= valid_next;
            time_reg     <= time_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            if (state_reg == sdwt_pkg::ST_DONE && (!res_vld_reg || out_ready))
            begin
                res_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prev_reg     <= cnt_reg[IDX_W-1:0];
        hit_idx_reg  <= hit_idx_next;
        hit_ent_reg  <= hit_ent_next;
        free_idx_reg <= free_idx_next;
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd;
            key_reg <= {msg_kind, addr_hi, addr_lo, addr_family, prefix_len};
            seq_reg <= seqno;
            vt_reg  <= valid_ticks;
            verdict_reg <= sdwt_pkg::V_NEWEST;
            full_reg    <= 1'b0;
        end
        else if (res_load)
        begin
            verdict_reg <= res_verdict;
            full_reg    <= res_full;
        end
    end

    // Drive result from a dedicated output register
    logic [1:0] out_verdict_reg;
    logic       out_full_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == sdwt_pkg::ST_DONE && (!res_vld_reg || out_ready))
        begin
            out_verdict_reg <= verdict_reg;
            out_full_reg    <= full_reg;
        end
    end

    assign out_valid  = res_vld_reg;
    assign verdict    = out_verdict_reg;
    assign table_full = out_full_reg;

endmodule

@@ design/sdwt_checker.sv @@
module sdwt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] verdict,
    input logic       table_full
);

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(table_full))
        else $error("result changed while stalled");

    // Full flag only comes with a too-old verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> verdict == sdwt_pkg::V_OLD)
        else $error("table_full without too-old verdict");

    // No new request in the cycle right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken back to back");

    // A result never appears the cycle after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result without work time");

endmodule

bind seqno_duplicate_window_table sdwt_checker u_sdwt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .verdict    (verdict),
    .table_full (table_full)
);
